>>> rtl/vcpi_pkg.sv
// shared constants, types and helpers of the video chip cpu port
package vcpi_pkg;

	// video memory size in bytes (4096 to 16384), mirrored over the 14-bit address space
	localparam int VRAM_BYTES   = 16384;
	localparam int ACTIVE_LINES = 192;

	localparam int ADDR_W       = 14;
	localparam int ADDR_SPAN    = 1 << ADDR_W;
	localparam int MEM_AW       = (VRAM_BYTES > 1) ? $clog2(VRAM_BYTES) : 1;
	localparam int MIRROR_STEPS = (ADDR_SPAN - 1) / VRAM_BYTES;

	localparam int LINE_W       = 9;
	localparam logic [LINE_W-1:0] FRAME_FLAG_LINE = LINE_W'(ACTIVE_LINES + 1);
	localparam logic [LINE_W:0]   LINES_NTSC      = (LINE_W + 1)'(262);
	localparam logic [LINE_W:0]   LINES_PAL       = (LINE_W + 1)'(313);

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [MEM_AW-1:0] mem_addr_t;

	// bus request codes
	typedef enum logic [2:0] {
		CMD_DATA_READ     = 3'd0,
		CMD_DATA_WRITE    = 3'd1,
		CMD_STATUS_READ   = 3'd2,
		CMD_CONTROL_WRITE = 3'd3,
		CMD_LINE_TICK     = 3'd4
	} cmd_t;

	// access codes from the second control byte
	typedef enum logic [1:0] {
		CODE_VRAM_READ  = 2'd0,
		CODE_VRAM_WRITE = 2'd1,
		CODE_REG_WRITE  = 2'd2,
		CODE_NO_STORE   = 2'd3
	} code_t;

	localparam logic [3:0] REG_MODE1     = 4'd1;
	localparam int         FRAME_INT_BIT = 5;

	// fold the access address onto the memory (mirroring)
	function automatic mem_addr_t mem_index(input addr_t addr);
		logic [ADDR_W-1:0] idx;
		idx = addr;
		for (int i = 0; i < MIRROR_STEPS; i++) begin
			if (idx >= ADDR_W'(VRAM_BYTES)) begin
				idx = idx - ADDR_W'(VRAM_BYTES);
			end
		end
		return idx[MEM_AW-1:0];
	endfunction

endpackage

>>> rtl/vcpi_ram.sv
// generic single-port ram with registered read
module vcpi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/video_chip_cpu_port_interface.sv
// processor-side port of a tile video chip: video memory, address, control latch, status
//
// One request (data read, data write, status read, control write or scanline
// tick) is taken per clock and its single response appears in the output
// register on the next cycle, so the sustained rate is one request per cycle
// while in_stall is low; the pace is set by the single port of the video memory,
// which serves at most one read or one write per cycle. After reset the block
// first sweeps the video memory to zero, one byte a cycle, and in_stall stays
// high until the sweep is done, before the first request is taken. The format
// register (pal_format) is always ready; the user must write it only while the
// block is idle, which the block itself does not enforce. A response that is
// not taken holds the output register and stalls the request side.
module video_chip_cpu_port_interface (
	input  logic       clk,
	input  logic       arst_n,
	// request channel
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] command,
	input  logic [7:0] bus_value,
	// response channel
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] read_data,
	output logic       interrupt_request,
	// format register write
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       pal_format
);

	// clearing sweep after reset
	logic                  clr_busy_q;
	vcpi_pkg::mem_addr_t   clr_addr_q;

	// architectural state
	vcpi_pkg::addr_t       addr_q;
	logic                  pending_q;     // first control byte latched
	vcpi_pkg::code_t       code_q;
	logic                  int_en_q;      // mode register 1, frame interrupt enable
	logic                  frame_flag_q;  // the only status bit this port sets
	logic [vcpi_pkg::LINE_W-1:0] line_q;
	logic                  pal_q;
	logic                  pf_loaded_q;   // read-ahead byte lives in the ram read register

	// response register
	logic                  out_valid_q;
	logic [7:0]            read_data_q;
	logic                  irq_q;

	// next-state values
	vcpi_pkg::addr_t       addr_d;
	logic                  pending_d;
	vcpi_pkg::code_t       code_d;
	logic                  int_en_d;
	logic                  frame_flag_d;
	logic [vcpi_pkg::LINE_W-1:0] line_d;
	logic                  pf_loaded_d;
	logic [7:0]            result_d;

	// memory access of this request
	vcpi_pkg::addr_t       acc_addr;
	logic                  mem_rd;
	logic                  mem_wr;

	logic                  in_fire;
	logic [7:0]            prefetch;
	logic [7:0]            ram_rdata;
	logic [vcpi_pkg::LINE_W:0] line_inc;
	logic [vcpi_pkg::LINE_W:0] line_total;
	vcpi_pkg::addr_t       ctrl_addr;
	vcpi_pkg::code_t       ctrl_code;

	// a waiting response blocks new requests, and so does the clearing sweep
	assign in_stall  = clr_busy_q | (out_valid_q & out_stall);
	assign in_fire   = in_valid & ~in_stall;
	assign cfg_ready = 1'b1;

	// read-ahead byte reads as zero until the first prefetch
	assign prefetch = pf_loaded_q ? ram_rdata : 8'h00;

	// address and code formed by a second control byte
	assign ctrl_addr = {bus_value[5:0], addr_q[7:0]};
	assign ctrl_code = vcpi_pkg::code_t'(bus_value[7:6]);

	assign line_inc   = {1'b0, line_q} + 1'b1;
	assign line_total = pal_q ? vcpi_pkg::LINES_PAL : vcpi_pkg::LINES_NTSC;

	always_comb begin
		addr_d       = addr_q;
		pending_d    = pending_q;
		code_d       = code_q;
		int_en_d     = int_en_q;
		frame_flag_d = frame_flag_q;
		line_d       = line_q;
		pf_loaded_d  = pf_loaded_q;
		result_d     = 8'h00;
		acc_addr     = addr_q;
		mem_rd       = 1'b0;
		mem_wr       = 1'b0;

		case (command)
			vcpi_pkg::CMD_DATA_READ: begin
				result_d    = prefetch;
				pending_d   = 1'b0;
				mem_rd      = 1'b1;
				pf_loaded_d = 1'b1;
				addr_d      = addr_q + 1'b1;
			end
			vcpi_pkg::CMD_DATA_WRITE: begin
				pending_d = 1'b0;
				mem_wr    = (code_q != vcpi_pkg::CODE_NO_STORE);
				addr_d    = addr_q + 1'b1;
			end
			vcpi_pkg::CMD_STATUS_READ: begin
				result_d     = {frame_flag_q, 7'b0};
				frame_flag_d = 1'b0;
				pending_d    = 1'b0;
			end
			vcpi_pkg::CMD_CONTROL_WRITE: begin
				if (!pending_q) begin
					pending_d = 1'b1;
					addr_d    = {addr_q[13:8], bus_value};
				end else begin
					pending_d = 1'b0;
					addr_d    = ctrl_addr;
					code_d    = ctrl_code;
					acc_addr  = ctrl_addr;
					if (ctrl_code == vcpi_pkg::CODE_VRAM_READ) begin
						// read setup prefetches and steps the address
						mem_rd      = 1'b1;
						pf_loaded_d = 1'b1;
						addr_d      = ctrl_addr + 1'b1;
					end else if (ctrl_code == vcpi_pkg::CODE_REG_WRITE) begin
						// only register 1 bit 5 reaches the outputs
						if (bus_value[3:0] == vcpi_pkg::REG_MODE1) begin
							int_en_d = addr_q[vcpi_pkg::FRAME_INT_BIT];
						end
					end
				end
			end
			vcpi_pkg::CMD_LINE_TICK: begin
				if (line_q == vcpi_pkg::FRAME_FLAG_LINE) begin
					frame_flag_d = 1'b1;
				end
				// also wraps a counter left past the end by a format change
				if (line_inc >= line_total) begin
					line_d = '0;
				end else begin
					line_d = line_inc[vcpi_pkg::LINE_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	vcpi_ram #(
		.WIDTH(8),
		.DEPTH(vcpi_pkg::VRAM_BYTES)
	) u_vram (
		.clk  (clk),
		.we   (clr_busy_q | (in_fire & mem_wr)),
		.re   (in_fire & mem_rd),
		.addr (clr_busy_q ? clr_addr_q : vcpi_pkg::mem_index(acc_addr)),
		.wdata(clr_busy_q ? 8'h00 : bus_value),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q   <= 1'b1;
			clr_addr_q   <= '0;
			addr_q       <= '0;
			pending_q    <= 1'b0;
			code_q       <= vcpi_pkg::CODE_VRAM_READ;
			int_en_q     <= 1'b0;
			frame_flag_q <= 1'b0;
			line_q       <= '0;
			pal_q        <= 1'b0;
			pf_loaded_q  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == vcpi_pkg::MEM_AW'(vcpi_pkg::VRAM_BYTES - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (cfg_valid) begin
				pal_q <= pal_format;
			end
			if (in_fire) begin
				addr_q       <= addr_d;
				pending_q    <= pending_d;
				code_q       <= code_d;
				int_en_q     <= int_en_d;
				frame_flag_q <= frame_flag_d;
				line_q       <= line_d;
				pf_loaded_q  <= pf_loaded_d;
				out_valid_q  <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// response payload, no reset needed
	always_ff @(posedge clk) begin
		if (in_fire) begin
			read_data_q <= result_d;
			irq_q       <= int_en_d & frame_flag_d;
		end
	end

	assign out_valid         = out_valid_q;
	assign read_data         = read_data_q;
	assign interrupt_request = irq_q;

endmodule
